>>> sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console character writer: the
// operation codes, control characters, sequencer states and field widths.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int FUNC_W = 2;
    localparam int CHAR_W = 8;
    localparam int POSX_W = 6;
    localparam int POSY_W = 5;
    localparam int OROW_W = 5;
    localparam int OCOL_W = 6;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_SET   = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0a;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CHAR_QMARK = 8'h3f;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_CHAR,
        ST_CLEAR,
        ST_RDWAIT,
        ST_FIN
    } state_t;

endpackage

>>> sv/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text console over a ROWS x COLUMNS character map with cursor, line wrap,
// tab, scroll, clear and cell read.
//
// Usage:
//   s_tdata carries one operation word (put byte, set cursor, clear, read
//   cell); m_tdata returns one result word per operation with the read
//   data and the cursor after the operation. cfg_valid/cfg_data write
//   print_enable; write it only while the block is idle.
//   Rows are held in a rotating order: a scroll advances the row base and
//   blanks one row, so no rows are copied.
//   Each operation runs from idle through an execute state and, as needed,
//   a row blank, a character step or a read wait, to a finish state that
//   loads the result word; a put that scrolls blanks one row and a clear
//   writes every cell. The result word shows in the same cycle as the
//   block is ready again. The single memory port and the shared address
//   unit serialize these steps.
//   s_tready is high only in idle. A finished result waits in the output
//   register; the next word may be accepted meanwhile, and its result is
//   held back until m_tready takes the pending one.
//   After reset the map is cleared by a pass over all ROWS*COLUMNS cells
//   with s_tready low; the cursor starts at row ROWS-1, column 0.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
    parameter int COLUMNS  = 42,
    parameter int ROWS     = 22,
    parameter int TAB_STEP = 3
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [1:0] func, [9:2] char_byte, [15:10] pos_x, [20:16] pos_y
    input  logic [tcw_pkg::S_DATA_W-1:0] s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [7:0] read_data, [12:8] cursor_row, [18:13] cursor_col
    output logic [tcw_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int CW    = $clog2(COLUMNS + TAB_STEP);

    state_t            state_reg, state_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    func_t             func_reg, func_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic [POSX_W-1:0] px_reg, px_next;
    logic [POSY_W-1:0] py_reg, py_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     base_reg, base_next;
    logic              skip_reg, skip_next;
    logic              en_reg;
    logic [CHAR_W-1:0] rd_reg, rd_next;
    logic              m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic [RW-1:0]     au_row;
    logic [CW-1:0]     au_col;
    logic [AW-1:0]     au_addr;
    logic [AW-1:0]     mem_addr;
    logic              mem_we;
    logic [CHAR_W-1:0] mem_wdata;
    logic [CHAR_W-1:0] mem_rdata;
    logic [RW-1:0]     row_w;

    tcw_addr_unit #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS),
        .RW      (RW),
        .CW      (CW),
        .AW      (AW)
    ) u_addr (
        .base (base_reg),
        .row  (au_row),
        .col  (au_col),
        .addr (au_addr)
    );

    tcw_char_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .addr    (mem_addr),
        .wr_data (mem_wdata),
        .rd_data (mem_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            cnt_reg     <= '0;
            row_reg     <= RW'(ROWS - 1);
            col_reg     <= '0;
            base_reg    <= '0;
            skip_reg    <= 1'b0;
            en_reg      <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            base_reg    <= base_next;
            skip_reg    <= skip_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                en_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        char_reg   <= char_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        rd_reg     <= rd_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        func_next    = func_reg;
        char_next    = char_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        base_next    = base_reg;
        skip_next    = skip_reg;
        rd_next      = rd_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        m_data_next  = m_data_reg;
        au_row       = row_reg;
        au_col       = col_reg;
        mem_we       = 1'b0;
        mem_wdata    = '0;
        mem_addr     = au_addr;
        row_w        = row_reg;

        unique case (state_reg)
            ST_INIT: begin
                mem_we   = 1'b1;
                mem_addr = cnt_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == AW'(CELLS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next  = func_t'(s_tdata[1:0]);
                    char_next  = s_tdata[9:2];
                    px_next    = s_tdata[15:10];
                    py_next    = s_tdata[20:16];
                    rd_next    = '0;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                state_next = ST_FIN;
                unique case (func_reg)
                    FUNC_PUT: begin
                        if (!en_reg) begin
                            // printing off: drop the word
                        end else if (skip_reg || char_reg == CHAR_NUL) begin
                            skip_next = 1'b0;
                        end else begin
                            skip_next = char_reg[CHAR_W-1];
                            if (char_reg[CHAR_W-1]) begin
                                char_next = CHAR_QMARK;
                            end
                            // complete a pending wrap
                            if (col_reg >= CW'(COLUMNS)) begin
                                col_next = '0;
                                row_w    = row_reg + 1'b1;
                            end
                            // then a pending scroll: advance the row base
                            if (row_w >= RW'(ROWS)) begin
                                row_next   = RW'(ROWS - 1);
                                base_next  = (base_reg == RW'(ROWS - 1)) ? '0
                                                                         : base_reg + 1'b1;
                                cnt_next   = '0;
                                state_next = ST_SCROLL;
                            end else begin
                                row_next   = row_w;
                                state_next = ST_CHAR;
                            end
                        end
                    end
                    FUNC_SET: begin
                        row_next = ({1'b0, py_reg} < (POSY_W+1)'(ROWS))
                                   ? RW'(py_reg) : RW'(ROWS - 1);
                        col_next = ({1'b0, px_reg} < (POSX_W+1)'(COLUMNS))
                                   ? CW'(px_reg) : CW'(COLUMNS - 1);
                    end
                    FUNC_CLEAR: begin
                        row_next   = '0;
                        col_next   = '0;
                        base_next  = '0;
                        cnt_next   = '0;
                        state_next = ST_CLEAR;
                    end
                    FUNC_READ: begin
                        if ({1'b0, px_reg} < (POSX_W+1)'(COLUMNS) &&
                            {1'b0, py_reg} < (POSY_W+1)'(ROWS)) begin
                            au_row     = RW'(py_reg);
                            au_col     = CW'(px_reg);
                            state_next = ST_RDWAIT;
                        end
                    end
                    default: begin
                        state_next = ST_FIN;
                    end
                endcase
            end

            ST_SCROLL: begin
                // blank the row that became the bottom line
                au_row   = RW'(ROWS - 1);
                au_col   = cnt_reg[CW-1:0];
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == AW'(COLUMNS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_CHAR;
                end
            end

            ST_CHAR: begin
                state_next = ST_FIN;
                if (char_reg >= CHAR_LF && char_reg <= CHAR_CR) begin
                    row_next = row_reg + 1'b1;
                    col_next = '0;
                end else if (char_reg == CHAR_TAB) begin
                    col_next = col_reg + CW'(TAB_STEP);
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = char_reg;
                    col_next  = col_reg + 1'b1;
                end
            end

            ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = cnt_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == AW'(CELLS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end
            end

            ST_RDWAIT: begin
                rd_next    = mem_rdata;
                state_next = ST_FIN;
            end

            ST_FIN: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(M_DATA_W - CHAR_W - OROW_W - OCOL_W)'(0),
                                    OCOL_W'(col_reg), OROW_W'(row_reg), rd_reg};
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/tcw_char_ram.sv
// ----------------------------------------------------------------------------
// tcw_char_ram
// Character map storage: one shared address, synchronous write, registered
// read of the addressed cell.
// ----------------------------------------------------------------------------
module tcw_char_ram #(
    parameter int DEPTH = 924,
    parameter int AW    = 10
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             addr,
    input  logic [tcw_pkg::CHAR_W-1:0] wr_data,
    output logic [tcw_pkg::CHAR_W-1:0] rd_data
);
    import tcw_pkg::*;

    logic [CHAR_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        rd_data <= mem[addr];
    end

endmodule

>>> sv/tcw_addr_unit.sv
// ----------------------------------------------------------------------------
// tcw_addr_unit
// Shared cell address unit: rotates a screen row by the scroll base and
// forms row * COLUMNS + column.
// ----------------------------------------------------------------------------
module tcw_addr_unit #(
    parameter int ROWS    = 22,
    parameter int COLUMNS = 42,
    parameter int RW      = 5,
    parameter int CW      = 6,
    parameter int AW      = 10
) (
    input  logic [RW-1:0] base,
    input  logic [RW-1:0] row,
    input  logic [CW-1:0] col,
    output logic [AW-1:0] addr
);
    import tcw_pkg::*;

    logic [RW:0]   row_sum;
    logic [RW-1:0] phys_row;

    always_comb begin
        row_sum = {1'b0, row} + {1'b0, base};
        // wrap the rotated row back into the map
        if (row_sum >= (RW+1)'(ROWS)) begin
            phys_row = RW'(row_sum - (RW+1)'(ROWS));
        end else begin
            phys_row = RW'(row_sum);
        end
        addr = AW'(phys_row) * AW'(COLUMNS) + AW'(col);
    end

endmodule

>>> tb/text_console_char_writer_checker.sv
// ----------------------------------------------------------------------------
// text_console_char_writer_checker
// Watches the operation, result and print-enable channels of the console
// writer, keeps its own copy of the character map and cursor, and checks
// every result word field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module text_console_char_writer_checker #(
    parameter int COLUMNS  = 42,
    parameter int ROWS     = 22,
    parameter int TAB_STEP = 3
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    // [1:0] func, [9:2] char_byte, [15:10] pos_x, [20:16] pos_y
    input  logic [tcw_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    // [7:0] read_data, [12:8] cursor_row, [18:13] cursor_col
    input  logic [tcw_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic                         cfg_data,
    output int                           error_count,
    output int                           pending,
    output int                           checked,
    output int                           scrolls
);
    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int VIEW_W = OCOL_W + OROW_W + CHAR_W;

    // packed from the top bit down, so it lines up with m_tdata
    typedef struct packed {
        logic [OCOL_W-1:0] col;
        logic [OROW_W-1:0] row;
        logic [CHAR_W-1:0] rdata;
    } console_view_t;

    logic [CHAR_W-1:0] screen [CELLS];
    int                cur_row;
    int                cur_col;
    bit                skip_pending;
    bit                print_on;
    console_view_t     expected_views [$];
    int                errs;
    int                n_checked;
    int                n_scrolls;

    task automatic blank_screen();
        for (int i = 0; i < CELLS; i++) screen[i] = '0;
    endtask

    task automatic scroll_screen();
        for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = '0;
        n_scrolls++;
    endtask

    task automatic place_glyph(input logic [CHAR_W-1:0] c);
        int idx;
        // finish a pending wrap, then a pending scroll
        if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= ROWS) begin
            cur_row = ROWS - 1;
            scroll_screen();
        end
        if (c >= CHAR_LF && c <= CHAR_CR) begin
            cur_row++;
            cur_col = 0;
        end else if (c == CHAR_TAB) begin
            cur_col += TAB_STEP;
        end else begin
            idx = cur_row * COLUMNS + cur_col;
            if (idx < CELLS) screen[idx] = c;
            cur_col++;
        end
    endtask

    task automatic run_operation(input logic [S_DATA_W-1:0] word, output console_view_t view);
        func_t             op;
        logic [CHAR_W-1:0] ch;
        logic [POSX_W-1:0] px;
        logic [POSY_W-1:0] py;
        logic [CHAR_W-1:0] rd_val;
        op     = func_t'(word[1:0]);
        ch     = word[9:2];
        px     = word[15:10];
        py     = word[20:16];
        rd_val = '0;
        case (op)
            FUNC_PUT: begin
                if (print_on) begin
                    if (skip_pending) begin
                        skip_pending = 1'b0;
                    end else if (ch == CHAR_NUL) begin
                        skip_pending = 1'b0;
                    end else if (ch[CHAR_W-1]) begin
                        place_glyph(CHAR_QMARK);
                        skip_pending = 1'b1;
                    end else begin
                        place_glyph(ch);
                    end
                end
            end
            FUNC_SET: begin
                cur_row = (int'(py) < ROWS) ? int'(py) : ROWS - 1;
                cur_col = (int'(px) < COLUMNS) ? int'(px) : COLUMNS - 1;
            end
            FUNC_CLEAR: begin
                blank_screen();
                cur_row = 0;
                cur_col = 0;
            end
            default: begin
                if (int'(px) < COLUMNS && int'(py) < ROWS)
                    rd_val = screen[int'(py) * COLUMNS + int'(px)];
            end
        endcase
        view.rdata = rd_val;
        view.row   = cur_row[OROW_W-1:0];
        view.col   = cur_col[OCOL_W-1:0];
    endtask

    always @(posedge aclk) begin : watch
        console_view_t got;
        console_view_t want;
        if (!aresetn) begin
            blank_screen();
            cur_row      = ROWS - 1;
            cur_col      = 0;
            skip_pending = 1'b0;
            print_on     = 1'b1;
            expected_views.delete();
        end else begin
            if (cfg_valid && cfg_ready) print_on = cfg_data;
            if (m_tvalid && m_tready) begin
                got = m_tdata[VIEW_W-1:0];
                if (expected_views.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: result word %h arrived with nothing outstanding",
                                 $time, m_tdata);
                end else begin
                    want = expected_views.pop_front();
                    n_checked++;
                    if (got !== want) begin
                        errs++;
                        if (errs <= 10)
                            $display({"%0t: result %0d mismatch: cell exp %h got %h, ",
                                      "row exp %0d got %0d, col exp %0d got %0d"},
                                     $time, n_checked, want.rdata, got.rdata,
                                     want.row, got.row, want.col, got.col);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                run_operation(s_tdata, want);
                expected_views.push_back(want);
            end
        end
        error_count <= errs;
        pending     <= expected_views.size();
        checked     <= n_checked;
        scrolls     <= n_scrolls;
    end

endmodule

>>> tb/text_console_char_writer_tb.sv
// ----------------------------------------------------------------------------
// text_console_char_writer_tb
// Drives the console writer with a directed opening (wrap, scroll, control
// codes, high and skipped bytes, clamped cursor sets, clear, reads in and
// out of the map) and then random text, cursor moves, reads and clears
// across several print-enable settings, with bursty input, a stalling
// result side and one long hold-off. Checking lives in the checker module.
// ----------------------------------------------------------------------------
module text_console_char_writer_tb;
    import tcw_pkg::*;

    localparam int COLUMNS   = 42;
    localparam int ROWS      = 22;
    localparam int TAB_STEP  = 3;
    localparam int LONG_HOLD = 400;
    localparam int N_PHASES  = 5;

    typedef enum int {
        SINK_OPEN,
        SINK_HALF,
        SINK_MOSTLY,
        SINK_SPARSE
    } sink_mode_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    // [1:0] func, [9:2] char_byte, [15:10] pos_x, [20:16] pos_y
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    // [7:0] read_data, [12:8] cursor_row, [18:13] cursor_col
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_data  = 1'b0;
    logic                hold_armed = 1'b0;

    int error_count;
    int pending;
    int checked;
    int scrolls;
    int burst_left;
    int n_put, n_set, n_clear, n_read, n_cfg;

    text_console_char_writer #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STEP (TAB_STEP)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    text_console_char_writer_checker #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STEP (TAB_STEP)
    ) console_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .pending     (pending),
        .checked     (checked),
        .scrolls     (scrolls)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("timeout: results still outstanding or input never accepted");
        $display("FAILED: results differ");
        $finish;
    end

    // Send one operation word; open a new burst with a random gap when due.
    task automatic send_op(input func_t f, input logic [CHAR_W-1:0] c,
                           input logic [POSX_W-1:0] x, input logic [POSY_W-1:0] y);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({y, x, c, f});
        do @(posedge aclk); while (!s_tready);
        case (f)
            FUNC_PUT:   n_put++;
            FUNC_SET:   n_set++;
            FUNC_CLEAR: n_clear++;
            default:    n_read++;
        endcase
    endtask

    // Drain all results, then write print_enable while the block is idle.
    task automatic write_print_enable(input logic v);
        s_tvalid  <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    task automatic random_op();
        int                r;
        func_t             f;
        logic [CHAR_W-1:0] c;
        logic [POSX_W-1:0] x;
        logic [POSY_W-1:0] y;
        r = $urandom_range(0, 99);
        c = CHAR_W'($urandom_range(0, 255));
        x = POSX_W'($urandom_range(0, 63));
        y = POSY_W'($urandom_range(0, 31));
        if (r < 55)      c = CHAR_W'($urandom_range(32, 126));
        else if (r < 63) c = CHAR_W'($urandom_range(9, 13));
        else if (r < 70) c = CHAR_W'($urandom_range(128, 255));
        else if (r < 73) c = CHAR_NUL;
        if (r < 76) begin
            f = FUNC_PUT;
        end else if (r < 86) begin
            f = FUNC_READ;
            // half of the reads land near the bottom rows, where the text is
            if (r < 81) begin
                y = POSY_W'($urandom_range(ROWS - 4, ROWS - 1));
                x = POSX_W'($urandom_range(0, COLUMNS - 1));
            end
        end else if (r < 98) begin
            f = FUNC_SET;
            // park near the end of the last rows to force wraps and scrolls
            if (r < 90) begin
                x = POSX_W'($urandom_range(COLUMNS - 3, COLUMNS - 1));
                y = POSY_W'($urandom_range(ROWS - 2, ROWS - 1));
            end
        end else begin
            f = FUNC_CLEAR;
        end
        send_op(f, c, x, y);
    endtask

    // Result side: change pacing every so often; hold off once for a long stretch.
    initial begin : result_sink
        sink_mode_t mode;
        int         span;
        bit         held;
        mode = SINK_OPEN;
        span = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_armed && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            if (span == 0) begin
                mode = sink_mode_t'($urandom_range(0, 3));
                span = $urandom_range(16, 200);
            end
            span--;
            case (mode)
                SINK_OPEN:   m_tready <= 1'b1;
                SINK_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
                SINK_MOSTLY: m_tready <= ($urandom_range(0, 4) != 0);
                default:     m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial begin : stimulus
        bit phase_enable [N_PHASES];
        int phase_len    [N_PHASES];
        phase_enable = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        phase_len    = '{900, 150, 700, 50, 200};
        burst_left   = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reads on the fresh map, inside and outside
        send_op(FUNC_READ, 8'h00, 6'd0, 5'd0);
        send_op(FUNC_READ, 8'hff, 6'd63, 5'd31);
        send_op(FUNC_PUT, "A", 6'd0, 5'd0);
        send_op(FUNC_PUT, CHAR_NUL, 6'd0, 5'd0);
        send_op(FUNC_SET, 8'h00, 6'(COLUMNS), 5'(ROWS));
        send_op(FUNC_SET, 8'h00, 6'd63, 5'd31);
        // fill the last cell: wrap pending, then wrap plus scroll
        send_op(FUNC_PUT, "B", 6'd0, 5'd0);
        send_op(FUNC_READ, 8'h00, 6'(COLUMNS - 1), 5'(ROWS - 1));
        send_op(FUNC_PUT, "C", 6'd0, 5'd0);
        send_op(FUNC_READ, 8'h00, 6'(COLUMNS - 1), 5'(ROWS - 2));
        // line codes leave a scroll pending; the next one completes it
        send_op(FUNC_PUT, CHAR_LF, 6'd0, 5'd0);
        send_op(FUNC_PUT, CHAR_CR, 6'd0, 5'd0);
        send_op(FUNC_PUT, 8'h0b, 6'd0, 5'd0);
        send_op(FUNC_PUT, 8'h0c, 6'd0, 5'd0);
        send_op(FUNC_PUT, CHAR_TAB, 6'd0, 5'd0);
        // high byte writes a question mark and drops the next put
        send_op(FUNC_PUT, 8'h80, 6'd0, 5'd0);
        send_op(FUNC_PUT, "D", 6'd0, 5'd0);
        send_op(FUNC_PUT, 8'hff, 6'd0, 5'd0);
        send_op(FUNC_READ, 8'h00, 6'd3, 5'(ROWS - 1));
        send_op(FUNC_PUT, CHAR_NUL, 6'd0, 5'd0);
        send_op(FUNC_PUT, CHAR_NUL, 6'd0, 5'd0);
        send_op(FUNC_PUT, 8'h7f, 6'd0, 5'd0);
        // tab past the edge, then wrap on the next tab
        send_op(FUNC_SET, 8'h00, 6'(COLUMNS - 2), 5'd0);
        send_op(FUNC_PUT, CHAR_TAB, 6'd0, 5'd0);
        send_op(FUNC_PUT, CHAR_TAB, 6'd0, 5'd0);
        send_op(FUNC_CLEAR, 8'h00, 6'd0, 5'd0);
        send_op(FUNC_READ, 8'h00, 6'd3, 5'(ROWS - 1));

        // puts ignored while printing is off
        write_print_enable(1'b0);
        send_op(FUNC_PUT, "E", 6'd0, 5'd0);
        send_op(FUNC_PUT, 8'h90, 6'd0, 5'd0);
        send_op(FUNC_READ, 8'h00, 6'd0, 5'd0);

        for (int p = 0; p < N_PHASES; p++) begin
            write_print_enable(phase_enable[p]);
            for (int i = 0; i < phase_len[p]; i++) begin
                if (p == 0 && i == 200) hold_armed <= 1'b1;
                random_op();
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("Covered %0d operations: %0d puts, %0d cursor sets, %0d clears, %0d reads",
                 n_put + n_set + n_clear + n_read, n_put, n_set, n_clear, n_read);
        $display("%0d results checked, %0d scrolls, %0d print_enable writes, %0d errors",
                 checked, scrolls, n_cfg, error_count);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> text_console_char_writer.f
sv/tcw_pkg.sv
sv/tcw_char_ram.sv
sv/tcw_addr_unit.sv
sv/text_console_char_writer.sv
tb/text_console_char_writer_checker.sv
tb/text_console_char_writer_tb.sv
